FILE: design/page_bitmap_allocator_defines.svh
// Assertion macros shared by the page allocator RTL.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pba_pkg.sv
// Constants and types of the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;

  localparam int PAGES      = 256;
  localparam int PAGE_W     = 8;
  localparam int CNT_W      = 9;
  localparam int BYTES_W    = 32;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_ZERO     = 2'd1;
  localparam status_t ST_NO_SPACE = 2'd2;
  localparam status_t ST_UNKNOWN  = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PAGES = 2'd2;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET   = 5'd12;
  localparam logic [CNT_W-1:0]   ACTIVE_PAGES_RESET = 9'd256;

endpackage

FILE: design/pba_if.sv
// Request and result channel interfaces of the page allocator.
`timescale 1ns / 1ps
interface pba_in_if import pba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BYTES_W-1:0] request_bytes;
  logic [PAGE_W-1:0]  free_page;

  modport source (output valid, kind, request_bytes, free_page, input ready);
  modport sink   (input valid, kind, request_bytes, free_page, output ready);
endinterface

interface pba_out_if import pba_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [PAGE_W-1:0] start_page;
  logic [CNT_W-1:0]  page_count;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  largest_run;

  modport source (output valid, status, start_page, page_count, free_pages, largest_run,
                  input ready);
  modport sink   (input valid, status, start_page, page_count, free_pages, largest_run,
                  output ready);
endinterface

FILE: design/page_bitmap_allocator.sv
// Page allocator over a free-page bitmap, first-fit or best-fit placement.
//
//   channel | dir | handshake       | payload
//   in_if   | in  | valid / ready   | kind, request_bytes, free_page
//   out_if  | out | valid / ready   | status, start_page, page_count, free_pages, largest_run
//   cfg_*   | in  | cfg_we          | cfg_index, cfg_data
//
// Allocate: one page per cycle through the bitmap, N = managed pages; once over the N
// for placement, once over all PAGES to mark pages and rebuild free totals.
// Free, zero-size and oversized requests: update pass only.
// Reset is synchronous; all pages come up free with no blocks granted.
// in_if.ready is high only while idle; a finished result waits in the output
// register and the next item is taken meanwhile.
`timescale 1ns / 1ps
`include "page_bitmap_allocator_defines.svh"
module page_bitmap_allocator import pba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pba_in_if.sink                in_if,
  pba_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic               strategy_r;
  logic [SHIFT_W-1:0] page_shift_r;
  logic [CNT_W-1:0]   active_r;
  logic [PAGES-1:0]   page_free_r;
  logic [PAGES-1:0]   block_start_r;
  logic [CNT_W-1:0]   block_len_mem [PAGES];
  logic [CNT_W-1:0]   len_rd_r;

  logic               kind_r;
  logic               zero_r;
  logic [BYTES_W:0]   sum_r;
  logic [PAGE_W-1:0]  fp_r;
  logic               bstart_r;
  logic [CNT_W-1:0]   need_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   run_len_r;
  logic [PAGE_W-1:0]  run_start_r;
  logic               found_r;
  logic [CNT_W-1:0]   best_len_r;
  logic [PAGE_W-1:0]  at_r;
  logic [PAGE_W-1:0]  lo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               set_val_r;
  status_t            status_r;
  logic [PAGE_W-1:0]  start_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   total_r;
  logic [CNT_W-1:0]   srun_r;
  logic [CNT_W-1:0]   best_run_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [PAGE_W-1:0]  out_start_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [CNT_W-1:0]   out_free_r;
  logic [CNT_W-1:0]   out_largest_r;

  logic               in_accept;
  logic [CNT_W-1:0]   n_managed;
  logic [BYTES_W:0]   round_mask;
  logic [BYTES_W:0]   need_full;
  logic               need_big;
  logic [CNT_W-1:0]   need_lo;
  logic               scan_go;
  logic               at_end;
  logic               cur_free;
  logic               take;
  logic [PAGE_W-1:0]  upd_page;
  logic [CNT_W-1:0]   off;
  logic               in_rng;
  logic               pf_new;
  logic               counted;
  logic [CNT_W-1:0]   srun_inc;
  logic               last;
  logic               out_load;
  logic               mem_we;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;

  assign n_managed  = (active_r > CNT_W'(PAGES)) ? CNT_W'(PAGES) : active_r;
  assign round_mask = ((BYTES_W+1)'(1) << page_shift_r) - (BYTES_W+1)'(1);
  assign need_full  = sum_r >> page_shift_r;
  assign need_big   = |need_full[BYTES_W:CNT_W];
  assign need_lo    = need_full[CNT_W-1:0];
  assign scan_go    = (kind_r == KIND_ALLOC) && !zero_r && !need_big && (need_lo <= n_managed);

  // placement scan: a run is judged when it ends on a used page or at the limit
  assign at_end   = (idx_r == n_managed);
  assign cur_free = page_free_r[idx_r[PAGE_W-1:0]];
  assign take     = (at_end || !cur_free) && (run_len_r >= need_r) &&
                    (!found_r || (strategy_r && (run_len_r < best_len_r)));

  // update pass: rewrite the block's pages and rebuild the totals
  assign upd_page = idx_r[PAGE_W-1:0];
  assign off      = idx_r - {1'b0, lo_r};
  assign in_rng   = (idx_r >= {1'b0, lo_r}) && (off < cnt_r);
  assign pf_new   = in_rng ? set_val_r : page_free_r[upd_page];
  assign counted  = (idx_r < n_managed);
  assign srun_inc = srun_r + CNT_W'(1);
  assign last     = (idx_r == CNT_W'(PAGES - 1));

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_if.ready);
  assign mem_we   = (state_r == S_PLACE) && found_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_PREP;
      S_PREP:  state_nxt = scan_go ? S_SCAN : S_UPD;
      S_SCAN:  if (at_end) state_nxt = S_PLACE;
      S_PLACE: state_nxt = S_UPD;
      S_UPD:   if (last) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      strategy_r    <= 1'b0;
      page_shift_r  <= PAGE_SHIFT_RESET;
      active_r      <= ACTIVE_PAGES_RESET;
      page_free_r   <= '1;
      block_start_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STRATEGY:     strategy_r   <= cfg_data[0];
          REG_PAGE_SHIFT:   page_shift_r <= cfg_data[SHIFT_W-1:0];
          REG_ACTIVE_PAGES: active_r     <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_PREP && kind_r == KIND_FREE && bstart_r) begin
        block_start_r[fp_r] <= 1'b0;
      end
      if (mem_we) begin
        block_start_r[at_r] <= 1'b1;
      end
      if (state_r == S_UPD) begin
        page_free_r[upd_page] <= pf_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // block length store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_len_mem[at_r] <= need_r;
    end
    len_rd_r <= block_len_mem[in_if.free_page];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          kind_r   <= in_if.kind;
          zero_r   <= (in_if.request_bytes == '0);
          sum_r    <= {1'b0, in_if.request_bytes} + round_mask;
          fp_r     <= in_if.free_page;
          bstart_r <= block_start_r[in_if.free_page];
        end
      end
      S_PREP: begin
        idx_r      <= '0;
        run_len_r  <= '0;
        found_r    <= 1'b0;
        total_r    <= '0;
        srun_r     <= '0;
        best_run_r <= '0;
        need_r     <= need_lo;
        if (kind_r == KIND_FREE) begin
          start_r   <= fp_r;
          lo_r      <= fp_r;
          set_val_r <= 1'b1;
          if (bstart_r) begin
            status_r <= ST_OK;
            cnt_r    <= len_rd_r;
            count_r  <= len_rd_r;
          end else begin
            status_r <= ST_UNKNOWN;
            cnt_r    <= '0;
            count_r  <= '0;
          end
        end else begin
          start_r   <= '0;
          lo_r      <= '0;
          set_val_r <= 1'b0;
          cnt_r     <= '0;
          count_r   <= '0;
          priority if (zero_r) begin
            status_r <= ST_ZERO;
          end else if (!scan_go) begin
            status_r <= ST_NO_SPACE;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          found_r    <= 1'b1;
          best_len_r <= run_len_r;
          at_r       <= run_start_r;
        end
        if (!at_end) begin
          if (cur_free) begin
            run_len_r <= run_len_r + CNT_W'(1);
            if (run_len_r == '0) begin
              run_start_r <= idx_r[PAGE_W-1:0];
            end
          end else begin
            run_len_r <= '0;
          end
          idx_r <= idx_r + CNT_W'(1);
        end
      end
      S_PLACE: begin
        idx_r <= '0;
        if (found_r) begin
          start_r <= at_r;
          lo_r    <= at_r;
          cnt_r   <= need_r;
          count_r <= need_r;
        end else begin
          status_r <= ST_NO_SPACE;
        end
      end
      S_UPD: begin
        idx_r <= idx_r + CNT_W'(1);
        if (counted) begin
          if (pf_new) begin
            total_r <= total_r + CNT_W'(1);
            srun_r  <= srun_inc;
            if (srun_inc > best_run_r) begin
              best_run_r <= srun_inc;
            end
          end else begin
            srun_r <= '0;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_status_r  <= status_r;
          out_start_r   <= start_r;
          out_count_r   <= count_r;
          out_free_r    <= total_r;
          out_largest_r <= best_run_r;
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.start_page  = out_start_r;
  assign out_if.page_count  = out_count_r;
  assign out_if.free_pages  = out_free_r;
  assign out_if.largest_run = out_largest_r;

  `PBA_ASSERT_SAME(a_ok_has_pages, out_valid_r && out_status_r == ST_OK, out_count_r != '0, "ok result with no pages")
  `PBA_ASSERT_SAME(a_fail_no_pages, out_valid_r && out_status_r != ST_OK, out_count_r == '0, "failed result with pages")
  `PBA_ASSERT_SAME(a_run_le_total, out_valid_r, out_largest_r <= out_free_r, "largest run above free total")
  `PBA_ASSERT_SAME(a_scan_bound, state_r == S_SCAN, idx_r <= n_managed, "scan past managed pages")
  `PBA_ASSERT_NEXT(a_load_idle, out_load, out_valid_r && state_r == S_IDLE, "result load did not complete")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the page bitmap allocator: directed and random requests.
`timescale 1ns / 1ps
module tb_top import pba_pkg::*; ();

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] start_page;
    logic [CNT_W-1:0]  page_count;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  largest_run;
  } alloc_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pba_in_if  req_ch ();
  pba_out_if rsp_ch ();

  page_bitmap_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the allocator: bitmap, block heads and lengths, register values
  bit            pg_free  [PAGES];
  bit            blk_head [PAGES];
  int unsigned   blk_len  [PAGES];
  bit            cur_strategy;
  int unsigned   cur_shift;
  int unsigned   cur_active;

  alloc_result_t pending_results [$];
  alloc_result_t want_res;
  alloc_result_t chk_res;
  int            error_count = 0;
  int unsigned   last_start;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_allocator();
    foreach (pg_free[i]) begin
      pg_free[i]  = 1'b1;
      blk_head[i] = 1'b0;
      blk_len[i]  = 0;
    end
    cur_strategy = 1'b0;
    cur_shift    = 32'(PAGE_SHIFT_RESET);
    cur_active   = 32'(ACTIVE_PAGES_RESET);
  endfunction

  function automatic int unsigned managed_pages();
    return (cur_active > PAGES) ? PAGES : cur_active;
  endfunction

  function automatic void free_stats(output int unsigned total, output int unsigned longest);
    int unsigned run;
    total   = 0;
    longest = 0;
    run     = 0;
    for (int i = 0; i < managed_pages(); i++) begin
      if (pg_free[i]) begin
        total++;
        run++;
        if (run > longest) longest = run;
      end else begin
        run = 0;
      end
    end
  endfunction

  // Whole free runs are measured; best fit keeps the shortest, lower run on a tie.
  function automatic bit find_run(longint unsigned need, output int unsigned at);
    int unsigned n, i, j, best_len;
    bit          found;
    n        = managed_pages();
    i        = 0;
    best_len = 0;
    found    = 1'b0;
    at       = 0;
    if (need > n) return 1'b0;
    while (i < n) begin
      if (!pg_free[i]) begin
        i++;
      end else begin
        j = i;
        while (j < n && pg_free[j]) j++;
        if (j - i >= need) begin
          if (!cur_strategy) begin
            at = i;
            return 1'b1;
          end
          if (!found || j - i < best_len) begin
            found    = 1'b1;
            best_len = j - i;
            at       = i;
          end
        end
        i = j;
      end
    end
    return found;
  endfunction

  function automatic alloc_result_t apply_request(logic kind, logic [BYTES_W-1:0] bytes,
                                                  logic [PAGE_W-1:0] page);
    alloc_result_t   res;
    longint unsigned need;
    int unsigned     at, total, longest;
    res = '0;
    if (kind == KIND_ALLOC) begin
      if (bytes == '0) begin
        res.status = ST_ZERO;
      end else begin
        need = ({32'd0, bytes} + (64'd1 << cur_shift) - 64'd1) >> cur_shift;
        if (find_run(need, at)) begin
          for (int unsigned p = at; p < at + need; p++) pg_free[p] = 1'b0;
          blk_head[at]   = 1'b1;
          blk_len[at]    = 32'(need);
          res.status     = ST_OK;
          res.start_page = PAGE_W'(at);
          res.page_count = CNT_W'(need);
        end else begin
          res.status = ST_NO_SPACE;
        end
      end
    end else begin
      res.start_page = page;
      if (blk_head[page]) begin
        for (int unsigned p = page; p < PAGES && p - page < blk_len[page]; p++)
          pg_free[p] = 1'b1;
        blk_head[page] = 1'b0;
        res.status     = ST_OK;
        res.page_count = CNT_W'(blk_len[page]);
      end else begin
        res.status = ST_UNKNOWN;
      end
    end
    free_stats(total, longest);
    res.free_pages  = CNT_W'(total);
    res.largest_run = CNT_W'(longest);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_request(input logic kind, input logic [BYTES_W-1:0] bytes,
                              input logic [PAGE_W-1:0] page);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    // now and then a long pause so the block sits idle with a result parked
    if (send_idle_pct != 0 && $urandom_range(19) == 0) gap += $urandom_range(600);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.request_bytes <= bytes;
    req_ch.free_page     <= page;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want_res = apply_request(kind, bytes, page);
    last_start = 32'(want_res.start_page);
    pending_results.push_back(want_res);
  endtask

  task automatic request_alloc(input logic [BYTES_W-1:0] bytes);
    send_request(KIND_ALLOC, bytes, PAGE_W'($urandom));
  endtask

  task automatic request_free(input int unsigned page);
    send_request(KIND_FREE, $urandom, PAGE_W'(page));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic apply_config(input int unsigned strat, input int unsigned shift,
                              input int unsigned active);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STRATEGY;
    cfg_data  <= CFG_DATA_W'(strat);
    @(posedge clk);
    cur_strategy = strat[0];
    cfg_index <= REG_PAGE_SHIFT;
    cfg_data  <= CFG_DATA_W'(shift);
    @(posedge clk);
    cur_shift = shift & 31;
    cfg_index <= REG_ACTIVE_PAGES;
    cfg_data  <= CFG_DATA_W'(active);
    @(posedge clk);
    cur_active = active & 511;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic release_all();
    for (int p = 0; p < PAGES; p++)
      if (blk_head[p]) request_free(p);
  endtask

  // Reset settings: first fit, 4 KB pages, all 256 pages managed
  task automatic test_alloc_basics();
    request_alloc(32'd0);
    request_alloc(32'd1);
    request_alloc(32'd4096);
    request_alloc(32'd4097);
    request_alloc(32'hFFFF_FFFF);
    request_alloc(32'd1 << 20);
    request_free(8'hFF);
    request_free(1);
    request_free(1);
    request_alloc(32'd100);
  endtask

  task automatic test_best_fit();
    int unsigned hole3, hole2, hole4;
    release_all();
    apply_config(1, 12, 256);
    request_alloc(3 * 4096);
    hole3 = last_start;
    request_alloc(4096);
    request_alloc(2 * 4096);
    hole2 = last_start;
    request_alloc(4096);
    request_alloc(4 * 4096);
    hole4 = last_start;
    request_alloc(4096);
    request_free(hole3);
    request_free(hole2);
    request_free(hole4);
    // each request should land in the tightest hole, not the first one
    request_alloc(2 * 4096);
    request_alloc(3 * 4096);
    request_alloc(4096);
  endtask

  task automatic test_config_extremes();
    release_all();
    apply_config(0, 0, 0);
    request_alloc(32'd1);
    // active pages above the array saturate; shift 31 gives 2 GB pages
    apply_config(1, 31, 300);
    request_alloc(32'hFFFF_FFFF);
    request_alloc(32'h8000_0000);
    request_alloc(32'h8000_0001);
    release_all();
    apply_config(0, 16, 256);
    request_alloc(32'h0100_0000);
    request_free(0);
  endtask

  task automatic test_shrink_active();
    int unsigned head_blk, tail_blk;
    apply_config(0, 12, 256);
    request_alloc(100 * 4096);
    head_blk = last_start;
    request_alloc(10 * 4096);
    tail_blk = last_start;
    // block past the new limit stays granted and can still be freed
    apply_config(0, 12, 50);
    request_free(tail_blk);
    request_alloc(32'd1);
    request_free(head_blk);
    request_alloc(50 * 4096);
    release_all();
  endtask

  task automatic test_random_traffic();
    int unsigned     strat_list  [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
    int unsigned     shift_list  [8] = '{12, 9, 0, 16, 4, 31, 12, 3};
    int unsigned     active_list [8] = '{256, 256, 128, 511, 64, 256, 1, 200};
    int unsigned     n, total, longest, at, base, pages, sel, r;
    longint unsigned span, val;
    bit              have;
    for (int ph = 0; ph < 8; ph++) begin
      apply_config(strat_list[ph], shift_list[ph], active_list[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      for (int k = 0; k < 150; k++) begin
        n = managed_pages();
        free_stats(total, longest);
        have = 1'b0;
        at   = 0;
        base = $urandom_range(PAGES - 1);
        for (int i = 0; i < PAGES && !have; i++) begin
          if (blk_head[(base + i) % PAGES]) begin
            have = 1'b1;
            at   = (base + i) % PAGES;
          end
        end
        r = $urandom_range(99);
        if (r < 8) begin
          send_request(1'($urandom_range(1)), $urandom, PAGE_W'($urandom_range(255)));
        end else if (r < 10) begin
          request_alloc('0);
        end else if (have && (r >= 55 || total * 4 < n)) begin
          request_free(at);
        end else begin
          sel   = $urandom_range(15);
          pages = (sel < 10) ? $urandom_range(8, 1) :
                  (sel < 14) ? $urandom_range(32, 1) : $urandom_range(PAGES, 1);
          // any byte count that rounds up to the chosen number of pages
          span = 64'd1 << cur_shift;
          val  = pages - 1;
          val  = (val << cur_shift) + 1 + $urandom_range(span - 1);
          request_alloc((val > 64'hFFFF_FFFF) ? $urandom : val[BYTES_W-1:0]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      rsp_ch.ready <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(99) == 0) begin
      hold_cycles  <= $urandom_range(700, 50);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected item, start page %0d", rsp_ch.start_page));
      end else begin
        chk_res = pending_results.pop_front();
        if (rsp_ch.status !== chk_res.status)
          flag_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, chk_res.status));
        if (rsp_ch.start_page !== chk_res.start_page)
          flag_mismatch($sformatf("start_page %0d, want %0d",
                                  rsp_ch.start_page, chk_res.start_page));
        if (rsp_ch.page_count !== chk_res.page_count)
          flag_mismatch($sformatf("page_count %0d, want %0d",
                                  rsp_ch.page_count, chk_res.page_count));
        if (rsp_ch.free_pages !== chk_res.free_pages)
          flag_mismatch($sformatf("free_pages %0d, want %0d",
                                  rsp_ch.free_pages, chk_res.free_pages));
        if (rsp_ch.largest_run !== chk_res.largest_run)
          flag_mismatch($sformatf("largest_run %0d, want %0d",
                                  rsp_ch.largest_run, chk_res.largest_run));
      end
    end
  end

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.kind          = KIND_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.free_page     = '0;
    cfg_we               = 1'b0;
    cfg_index            = REG_STRATEGY;
    cfg_data             = '0;
    rst_n                = 1'b0;
    clear_allocator();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alloc_basics();
    test_best_fit();
    test_config_extremes();
    test_shrink_active();
    test_random_traffic();

    wait_drained();
    repeat (600) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/pba_pkg.sv
design/pba_if.sv
design/page_bitmap_allocator.sv
test/tb_top.sv
